>>> hw/rtl/ihp_pkg.sv
// Shared types and constants for the IPv4 header parser.
package ihp_pkg;

   localparam logic [5:0] MIN_HEADER        = 6'd20;
   localparam logic [7:0] KIND_END          = 8'd0;
   localparam logic [7:0] KIND_NOP          = 8'd1;
   localparam logic [7:0] KIND_ROUTER_ALERT = 8'd148;

   localparam logic [5:0] POS_VER_IHL  = 6'd0;
   localparam logic [5:0] POS_TOS      = 6'd1;
   localparam logic [5:0] POS_LEN_HI   = 6'd2;
   localparam logic [5:0] POS_LEN_LO   = 6'd3;
   localparam logic [5:0] POS_IDENT_HI = 6'd4;
   localparam logic [5:0] POS_IDENT_LO = 6'd5;
   localparam logic [5:0] POS_FRAG_HI  = 6'd6;
   localparam logic [5:0] POS_FRAG_LO  = 6'd7;
   localparam logic [5:0] POS_TTL      = 6'd8;
   localparam logic [5:0] POS_PROTO    = 6'd9;
   localparam logic [5:0] POS_ADDR_LO  = 6'd12;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_req;
      logic [15:0] buffer_bytes;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  header_bytes;
      logic [7:0]  tos;
      logic [15:0] total_length;
      logic        length_clamped;
      logic [15:0] ident;
      logic [15:0] flags_fragment;
      logic [7:0]  ttl;
      logic [7:0]  proto;
      logic [63:0] addresses;
      logic        checksum_ok;
      logic        router_alert_seen;
      logic        unknown_option_seen;
   } rsp_word_type;

   typedef struct packed {
      logic       fire;
      logic       start;
      logic [5:0] pos;
      logic [7:0] data;
      logic [5:0] header_len;
   } step_type;

   typedef struct packed {
      logic alert;
      logic unknown;
   } opt_flags_type;

endpackage

>>> hw/rtl/ihp_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface ihp_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/ipv4_header_parser_core.sv
// Top level of the IPv4 header parser: field capture, length clamp, checksum and option checks, and result register.
//
//  channel  direction  word            notes
//  req_if   in         req_word_type   one packet byte, start mark, frame size
//  rsp_if   out        rsp_word_type   one parsed header, at its last byte
//
// One byte is taken per cycle unless the input stalls; each header byte updates the header state in the same cycle.
// The result appears in the output register the cycle after the last header byte.
// Reset clears the header tracking and the output valid flag.
// The input stalls only while a result waits in the output register and rsp_if.ready is low.
module ipv4_header_parser_core (
   input logic        clock,
   input logic        reset,
   ihp_stream_if.sink   req_if,
   ihp_stream_if.source rsp_if
);

   ihp_pkg::req_word_type  req_word;
   ihp_pkg::step_type      step;
   ihp_pkg::opt_flags_type opt_flags;
   ihp_pkg::rsp_word_type  rsp_word_ff, rsp_word_in;

   logic        accepted;
   logic        header_end;
   logic        sum_ok;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        in_header_ff, in_header_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [5:0]  ihl_bytes;
   logic [15:0] frame_ff, frame_in;
   logic [7:0]  tos_ff, tos_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] full_len;
   logic [15:0] clamp_len_ff, clamp_len_in;
   logic        clamp_flag_ff, clamp_flag_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] frag_ff, frag_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [63:0] addr_ff, addr_in;

   assign req_word      = req_if.payload;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign accepted      = req_if.valid && req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_word_ff;

   always_comb begin
      step.fire  = accepted && (req_word.start_req || in_header_ff);
      step.start = req_word.start_req;
      step.pos   = req_word.start_req ? 6'd0 : pos_ff;
      step.data  = req_word.data_byte;

      ihl_bytes = {req_word.data_byte[3:0], 2'b00};
      hlen_in   = hlen_ff;
      if (step.fire && step.pos == ihp_pkg::POS_VER_IHL) begin
         hlen_in = (ihl_bytes < ihp_pkg::MIN_HEADER) ? ihp_pkg::MIN_HEADER : ihl_bytes;
      end
      step.header_len = hlen_in;

      frame_in      = (step.fire && step.start) ? req_word.buffer_bytes : frame_ff;
      tos_in        = tos_ff;
      len_hi_in     = len_hi_ff;
      ident_in      = ident_ff;
      frag_in       = frag_ff;
      ttl_in        = ttl_ff;
      proto_in      = proto_ff;
      addr_in       = addr_ff;
      full_len      = {len_hi_ff, req_word.data_byte};
      clamp_len_in  = clamp_len_ff;
      clamp_flag_in = clamp_flag_ff;
      if (step.fire) begin
         case (step.pos)
            ihp_pkg::POS_TOS:      tos_in = step.data;
            ihp_pkg::POS_LEN_HI:   len_hi_in = step.data;
            ihp_pkg::POS_LEN_LO: begin
               clamp_flag_in = (full_len > frame_ff);
               clamp_len_in  = (full_len > frame_ff) ? frame_ff : full_len;
            end
            ihp_pkg::POS_IDENT_HI: ident_in[15:8] = step.data;
            ihp_pkg::POS_IDENT_LO: ident_in[7:0] = step.data;
            ihp_pkg::POS_FRAG_HI:  frag_in[15:8] = step.data;
            ihp_pkg::POS_FRAG_LO:  frag_in[7:0] = step.data;
            ihp_pkg::POS_TTL:      ttl_in = step.data;
            ihp_pkg::POS_PROTO:    proto_in = step.data;
            default: ;
         endcase
         if (step.pos >= ihp_pkg::POS_ADDR_LO && step.pos < ihp_pkg::MIN_HEADER) begin
            addr_in = {addr_ff[55:0], step.data};
         end
      end

      header_end   = step.fire && ({1'b0, step.pos} + 7'd1 >= {1'b0, hlen_in});
      pos_in       = step.fire ? step.pos + 6'd1 : pos_ff;
      in_header_in = in_header_ff;
      if (step.fire && step.start) begin
         in_header_in = 1'b1;
      end
      if (header_end) begin
         in_header_in = 1'b0;
      end

      rsp_word_in                     = rsp_word_ff;
      rsp_valid_in                    = rsp_valid_ff && !rsp_if.ready;
      if (header_end) begin
         rsp_valid_in                    = 1'b1;
         rsp_word_in.header_bytes        = hlen_in;
         rsp_word_in.tos                 = tos_in;
         rsp_word_in.total_length        = clamp_len_in;
         rsp_word_in.length_clamped      = clamp_flag_in;
         rsp_word_in.ident               = ident_in;
         rsp_word_in.flags_fragment      = {1'b0, frag_in[14:0]};
         rsp_word_in.ttl                 = ttl_in;
         rsp_word_in.proto               = proto_in;
         rsp_word_in.addresses           = addr_in;
         rsp_word_in.checksum_ok         = sum_ok;
         rsp_word_in.router_alert_seen   = opt_flags.alert;
         rsp_word_in.unknown_option_seen = opt_flags.unknown;
      end
   end

   ihp_checksum checksum (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .length_word (clamp_len_in),
      .sum_ok_in   (sum_ok)
   );

   ihp_option_walker option_walker (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .flags_in (opt_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff <= 1'b0;
         pos_ff       <= 6'd0;
         hlen_ff      <= ihp_pkg::MIN_HEADER;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_header_ff <= in_header_in;
         pos_ff       <= pos_in;
         hlen_ff      <= hlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff      <= frame_in;
      tos_ff        <= tos_in;
      len_hi_ff     <= len_hi_in;
      clamp_len_ff  <= clamp_len_in;
      clamp_flag_ff <= clamp_flag_in;
      ident_ff      <= ident_in;
      frag_ff       <= frag_in;
      ttl_ff        <= ttl_in;
      proto_ff      <= proto_in;
      addr_ff       <= addr_in;
      rsp_word_ff   <= rsp_word_in;
   end

   property stall_only_when_full;
      @(posedge clock) disable iff (reset) !req_if.ready |-> rsp_valid_ff;
   endproperty
   assert property (stall_only_when_full)
      else $error("Input stalled with an empty output register.");

   property end_leaves_header;
      @(posedge clock) disable iff (reset) header_end |=> !in_header_ff && rsp_valid_ff;
   endproperty
   assert property (end_leaves_header)
      else $error("Header end did not produce a result or close the header.");

   property pos_inside_header;
      @(posedge clock) disable iff (reset) in_header_ff |-> pos_ff < hlen_ff;
   endproperty
   assert property (pos_inside_header)
      else $error("Byte position ran past the header length.");

   property result_length_floor;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> rsp_word_ff.header_bytes >= ihp_pkg::MIN_HEADER;
   endproperty
   assert property (result_length_floor)
      else $error("Result header length below the minimum.");

endmodule

>>> hw/rtl/ihp_checksum.sv
// Ones'-complement header checksum accumulator with end-around carry.
module ihp_checksum (
   input  logic              clock,
   input  logic              reset,
   input  ihp_pkg::step_type step,
   input  logic [15:0]       length_word,
   output logic              sum_ok_in
);

   logic [7:0]  even_ff, even_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] sum_base;
   logic [15:0] word;
   logic [16:0] raw_sum;

   always_comb begin
      sum_base = step.start ? 16'd0 : sum_ff;
      word     = (step.pos == ihp_pkg::POS_LEN_LO) ? length_word : {even_ff, step.data};
      raw_sum  = {1'b0, sum_base} + {1'b0, word};
      even_in  = even_ff;
      sum_in   = sum_base;
      if (step.fire) begin
         if (!step.pos[0]) begin
            even_in = step.data;
         end else if (raw_sum[16]) begin
            sum_in = raw_sum[15:0] + 16'd1;
         end else begin
            sum_in = raw_sum[15:0];
         end
      end else begin
         sum_in = sum_ff;
      end
      sum_ok_in = (sum_in == 16'hFFFF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= 16'd0;
         even_ff <= 8'd0;
      end else begin
         sum_ff  <= sum_in;
         even_ff <= even_in;
      end
   end

endmodule

>>> hw/rtl/ihp_option_walker.sv
// Walks the IPv4 options and flags router alert and unknown or malformed options.
module ihp_option_walker (
   input  logic                   clock,
   input  logic                   reset,
   input  ihp_pkg::step_type      step,
   output ihp_pkg::opt_flags_type flags_in
);

   logic [5:0] next_opt_ff, next_opt_in;
   logic       phase_ff, phase_in;
   logic       done_ff, done_in;
   logic       alert_ff, alert_in;
   logic       unknown_ff, unknown_in;
   logic [8:0] opt_end;

   always_comb begin
      next_opt_in = next_opt_ff;
      phase_in    = phase_ff;
      done_in     = done_ff;
      alert_in    = alert_ff;
      unknown_in  = unknown_ff;
      opt_end     = {3'd0, next_opt_ff} + {1'b0, step.data};
      if (step.fire && step.start) begin
         next_opt_in = ihp_pkg::MIN_HEADER;
         phase_in    = 1'b0;
         done_in     = 1'b0;
         alert_in    = 1'b0;
         unknown_in  = 1'b0;
      end else if (step.fire && step.pos >= ihp_pkg::MIN_HEADER && !done_ff) begin
         if (!phase_ff) begin
            if (step.pos == next_opt_ff) begin
               if (step.data == ihp_pkg::KIND_END) begin
                  done_in = 1'b1;
               end else if (step.data == ihp_pkg::KIND_NOP) begin
                  next_opt_in = step.pos + 6'd1;
               end else begin
                  if (step.data == ihp_pkg::KIND_ROUTER_ALERT) begin
                     alert_in = 1'b1;
                  end else begin
                     unknown_in = 1'b1;
                  end
                  if ({1'b0, step.pos} + 7'd1 >= {1'b0, step.header_len}) begin
                     unknown_in = 1'b1;
                     done_in    = 1'b1;
                  end else begin
                     phase_in = 1'b1;
                  end
               end
            end
         end else begin
            // The current byte is the length of the option whose kind came before it.
            phase_in = 1'b0;
            if (step.data == 8'd0 || opt_end > {3'd0, step.header_len}) begin
               unknown_in = 1'b1;
               done_in    = 1'b1;
            end else if (step.data == 8'd1) begin
               next_opt_in = step.pos + 6'd1;
            end else begin
               next_opt_in = opt_end[5:0];
               if (opt_end == {3'd0, step.header_len}) begin
                  done_in = 1'b1;
               end
            end
         end
      end
      flags_in.alert   = alert_in;
      flags_in.unknown = unknown_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_opt_ff <= ihp_pkg::MIN_HEADER;
         phase_ff    <= 1'b0;
         done_ff     <= 1'b0;
         alert_ff    <= 1'b0;
         unknown_ff  <= 1'b0;
      end else begin
         next_opt_ff <= next_opt_in;
         phase_ff    <= phase_in;
         done_ff     <= done_in;
         alert_ff    <= alert_in;
         unknown_ff  <= unknown_in;
      end
   end

   property done_clears_phase;
      @(posedge clock) disable iff (reset) done_ff |-> !phase_ff;
   endproperty
   assert property (done_clears_phase)
      else $error("Option walk finished while waiting for a length byte.");

endmodule

>>> bench/ipv4_header_parser_core_tb.sv
// Self-checking testbench for the IPv4 header parser: directed and random packets, scoreboarded.
`timescale 1ns / 100ps

module ipv4_header_parser_core_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_WORDS = 1400;

   typedef logic [7:0] byte_q_type[$];

   class parse_scoreboard_type;
      logic        in_hdr;
      logic [5:0]  pos;
      logic [5:0]  hlen;
      logic [5:0]  next_opt;
      logic [15:0] frame;
      logic [15:0] len_raw;
      logic [15:0] ident;
      logic [15:0] frag;
      logic [7:0]  tos;
      logic [7:0]  ttl;
      logic [7:0]  proto;
      logic [7:0]  even;
      logic [63:0] addr;
      logic [16:0] sum;
      bit          opt_phase;
      bit          opt_done;
      bit          alert;
      bit          unknown;
      ihp_pkg::rsp_word_type expected_hdrs[$];
      int          errors;
      int          predicted;
      int          checked;
      int          n_alert;
      int          n_unknown;
      int          n_clamped;
      int          n_bad_sum;

      function new();
         clear_packet();
         frame = '0;
      endfunction

      static function logic [16:0] ones_add(logic [16:0] acc, logic [15:0] w);
         logic [16:0] s;
         s = acc + {1'b0, w};
         if (s > 17'h0FFFF) s = {1'b0, s[15:0]} + 17'd1;
         return s;
      endfunction

      function logic [15:0] clamped_length();
         return (len_raw > frame) ? frame : len_raw;
      endfunction

      function void clear_packet();
         in_hdr = 1'b0;
         pos = '0;
         hlen = ihp_pkg::MIN_HEADER;
         next_opt = ihp_pkg::MIN_HEADER;
         len_raw = '0;
         ident = '0;
         frag = '0;
         tos = '0;
         ttl = '0;
         proto = '0;
         even = '0;
         addr = '0;
         sum = '0;
         opt_phase = 1'b0;
         opt_done = 1'b0;
         alert = 1'b0;
         unknown = 1'b0;
      endfunction

      function void note_input(ihp_pkg::req_word_type w);
         logic [7:0]            b;
         int                    p;
         int                    e;
         ihp_pkg::rsp_word_type hdr;
         b = w.data_byte;
         if (w.start_req) begin
            clear_packet();
            frame = w.buffer_bytes;
            in_hdr = 1'b1;
         end else if (!in_hdr) begin
            return;
         end
         p = int'(pos);
         case (pos)
            ihp_pkg::POS_VER_IHL:
               hlen = (b[3:0] < 4'd5) ? ihp_pkg::MIN_HEADER : {b[3:0], 2'b00};
            ihp_pkg::POS_TOS: tos = b;
            ihp_pkg::POS_LEN_HI: len_raw = {b, 8'h00};
            ihp_pkg::POS_LEN_LO: len_raw[7:0] = b;
            ihp_pkg::POS_IDENT_HI: ident = {b, 8'h00};
            ihp_pkg::POS_IDENT_LO: ident[7:0] = b;
            ihp_pkg::POS_FRAG_HI: frag = {b, 8'h00};
            ihp_pkg::POS_FRAG_LO: frag[7:0] = b;
            ihp_pkg::POS_TTL: ttl = b;
            ihp_pkg::POS_PROTO: proto = b;
            default: ;
         endcase
         if (p >= int'(ihp_pkg::POS_ADDR_LO) && p < int'(ihp_pkg::MIN_HEADER))
            addr = {addr[55:0], b};
         if (pos[0] == 1'b0) begin
            even = b;
         end else begin
            sum = ones_add(sum, (pos == ihp_pkg::POS_LEN_LO) ? clamped_length() : {even, b});
         end
         if (p >= int'(ihp_pkg::MIN_HEADER) && !opt_done) begin
            if (!opt_phase) begin
               if (pos == next_opt) begin
                  if (b == ihp_pkg::KIND_END) begin
                     opt_done = 1'b1;
                  end else if (b == ihp_pkg::KIND_NOP) begin
                     next_opt = pos + 6'd1;
                  end else begin
                     if (b == ihp_pkg::KIND_ROUTER_ALERT) alert = 1'b1;
                     else unknown = 1'b1;
                     if (p + 1 >= int'(hlen)) begin
                        unknown = 1'b1;
                        opt_done = 1'b1;
                     end else begin
                        opt_phase = 1'b1;
                     end
                  end
               end
            end else begin
               e = int'(next_opt) + int'(b);
               opt_phase = 1'b0;
               if (b == 8'd0 || e > int'(hlen)) begin
                  unknown = 1'b1;
                  opt_done = 1'b1;
               end else if (b == 8'd1) begin
                  next_opt = pos + 6'd1;
               end else begin
                  next_opt = 6'(e);
                  if (e == int'(hlen)) opt_done = 1'b1;
               end
            end
         end
         pos = pos + 6'd1;
         if (p + 1 < int'(hlen)) return;
         in_hdr = 1'b0;
         hdr.header_bytes = hlen;
         hdr.tos = tos;
         hdr.total_length = clamped_length();
         hdr.length_clamped = (len_raw > frame);
         hdr.ident = ident;
         hdr.flags_fragment = {1'b0, frag[14:0]};
         hdr.ttl = ttl;
         hdr.proto = proto;
         hdr.addresses = addr;
         hdr.checksum_ok = (sum[15:0] == 16'hFFFF);
         hdr.router_alert_seen = alert;
         hdr.unknown_option_seen = unknown;
         expected_hdrs = {expected_hdrs, hdr};
         predicted++;
      endfunction

      function void check_result(ihp_pkg::rsp_word_type got);
         ihp_pkg::rsp_word_type want;
         string                 bad;
         checked++;
         if (expected_hdrs.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: header result with none expected: %p", got);
            return;
         end
         want = expected_hdrs.pop_front();
         bad = "";
         if (got.header_bytes !== want.header_bytes) bad = {bad, " header_bytes"};
         if (got.tos !== want.tos) bad = {bad, " tos"};
         if (got.total_length !== want.total_length) bad = {bad, " total_length"};
         if (got.length_clamped !== want.length_clamped) bad = {bad, " length_clamped"};
         if (got.ident !== want.ident) bad = {bad, " ident"};
         if (got.flags_fragment !== want.flags_fragment) bad = {bad, " flags_fragment"};
         if (got.ttl !== want.ttl) bad = {bad, " ttl"};
         if (got.proto !== want.proto) bad = {bad, " proto"};
         if (got.addresses !== want.addresses) bad = {bad, " addresses"};
         if (got.checksum_ok !== want.checksum_ok) bad = {bad, " checksum_ok"};
         if (got.router_alert_seen !== want.router_alert_seen) bad = {bad, " router_alert_seen"};
         if (got.unknown_option_seen !== want.unknown_option_seen)
            bad = {bad, " unknown_option_seen"};
         if (bad != "") begin
            errors++;
            if (errors <= 10)
               $display("ERROR: header %0d differs in%s\n  expected %p\n  actual   %p",
                        checked, bad, want, got);
         end
         if (want.router_alert_seen) n_alert++;
         if (want.unknown_option_seen) n_unknown++;
         if (want.length_clamped) n_clamped++;
         if (!want.checksum_ok) n_bad_sum++;
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   words_sent;
   int   cycles;
   parse_scoreboard_type sb;

   ihp_stream_if #(.payload_type(ihp_pkg::req_word_type)) req_if ();
   ihp_stream_if #(.payload_type(ihp_pkg::rsp_word_type)) rsp_if ();

   ipv4_header_parser_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_if.ready <= (int'($urandom_range(99)) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
         if (req_if.valid && req_if.ready) sb.note_input(req_if.payload);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
         $display("** ipv4_header_parser_core: FAILED **");
         $finish;
      end
   end

   function automatic byte_q_type make_header(input logic [7:0] ver_ihl, input logic [7:0] tos_v,
                                              input logic [15:0] tlen,
                                              input logic [15:0] frame_sz,
                                              input logic [15:0] id_v, input logic [15:0] frag_v,
                                              input logic [7:0] ttl_v, input logic [7:0] proto_v,
                                              input logic [63:0] addr_v, input byte_q_type opts,
                                              input bit fix_sum);
      byte_q_type  q;
      int          hl;
      logic [15:0] clen;
      logic [16:0] s;
      hl = (ver_ihl[3:0] < 4'd5) ? 20 : int'(ver_ihl[3:0]) * 4;
      q = '{ver_ihl, tos_v, tlen[15:8], tlen[7:0], id_v[15:8], id_v[7:0],
            frag_v[15:8], frag_v[7:0], ttl_v, proto_v, 8'h00, 8'h00};
      for (int i = 7; i >= 0; i--) q = {q, addr_v[i*8 +: 8]};
      for (int i = 20; i < hl; i++)
         q = {q, (i - 20 < opts.size()) ? opts[i-20] : ihp_pkg::KIND_END};
      if (fix_sum) begin
         clen = (tlen > frame_sz) ? frame_sz : tlen;
         s = '0;
         for (int i = 0; i < hl; i += 2) begin
            if (i == 2) s = parse_scoreboard_type::ones_add(s, clen);
            else if (i != 10) s = parse_scoreboard_type::ones_add(s, {q[i], q[i+1]});
         end
         q[10] = ~s[15:8];
         q[11] = ~s[7:0];
      end else begin
         q[10] = 8'($urandom);
         q[11] = 8'($urandom);
      end
      return q;
   endfunction

   task automatic send_word(input logic [7:0] d, input logic s, input logic [15:0] fsz);
      while (int'($urandom_range(99)) < idle_pct) begin
         req_if.valid <= 1'b0;
         req_if.payload <= ihp_pkg::req_word_type'(25'($urandom));
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= '{data_byte: d, start_req: s, buffer_bytes: fsz};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_packet(input byte_q_type pkt, input logic [15:0] fsz, input int trailer);
      foreach (pkt[i]) send_word(pkt[i], (i == 0), (i == 0) ? fsz : 16'($urandom));
      repeat (trailer) send_word(8'($urandom), 1'b0, 16'($urandom));
   endtask

   initial begin
      byte_q_type  pkt;
      byte_q_type  opts;
      int          hl;
      int          r;
      int          room;
      int          len;
      int          n;
      int          phase;
      logic [7:0]  v;
      logic [15:0] tlen;
      logic [15:0] fsz;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      idle_pct = 0;
      stall_pct = 0;
      words_sent = 0;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Words before any start mark must be ignored.
      repeat (3) send_word(8'($urandom), 1'b0, 16'($urandom));

      opts = {};
      pkt = make_header(8'h45, 8'hFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF,
                        64'hFFFF_FFFF_FFFF_FFFF, opts, 1'b1);
      send_packet(pkt, 16'h0000, 0);
      pkt = make_header(8'h40, 8'h00, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 8'hFF, 8'h00,
                        64'h0, opts, 1'b0);
      send_packet(pkt, 16'hFFFF, 0);
      pkt = make_header(8'h43, 8'h5A, 16'd20, 16'd20, 16'h1234, 16'h4000, 8'd64, 8'd6,
                        {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd20, 2);
      // A new start in the middle of a header drops it.
      pkt = pkt[0:9];
      send_packet(pkt, 16'd100, 0);
      pkt = make_header(8'hF5, 8'($urandom), 16'd40, 16'd60, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd60, 0);

      opts = '{ihp_pkg::KIND_ROUTER_ALERT, 8'd4, 8'd0, 8'd0};
      pkt = make_header(8'h46, 8'($urandom), 16'd24, 16'd24, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd24, 0);
      opts = '{ihp_pkg::KIND_NOP, ihp_pkg::KIND_NOP, ihp_pkg::KIND_NOP, ihp_pkg::KIND_END};
      pkt = make_header(8'h46, 8'($urandom), 16'd30, 16'd28, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd28, 0);
      opts = '{8'd7, 8'd4, 8'hAA, 8'h55};
      pkt = make_header(8'h46, 8'($urandom), 16'd24, 16'd500, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd500, 0);
      opts = '{8'd7, 8'd0};
      pkt = make_header(8'h46, 8'($urandom), 16'd24, 16'd24, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd24, 0);
      opts = '{ihp_pkg::KIND_ROUTER_ALERT, 8'd9};
      pkt = make_header(8'h46, 8'($urandom), 16'd24, 16'd24, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd24, 0);
      opts = '{ihp_pkg::KIND_NOP, ihp_pkg::KIND_NOP, ihp_pkg::KIND_NOP, 8'd5};
      pkt = make_header(8'h46, 8'($urandom), 16'd24, 16'd24, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd24, 0);
      opts = '{8'd3, 8'd1, ihp_pkg::KIND_NOP, ihp_pkg::KIND_END};
      pkt = make_header(8'h46, 8'($urandom), 16'd24, 16'd24, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd24, 0);
      opts = '{ihp_pkg::KIND_NOP, 8'd68, 8'd39};
      pkt = make_header(8'h4F, 8'($urandom), 16'd1500, 16'd1500, 16'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), {$urandom, $urandom}, opts, 1'b1);
      send_packet(pkt, 16'd1500, 5);

      while (words_sent < RANDOM_WORDS) begin
         phase = (words_sent / 350) % 4;
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 77;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 77;
            end
            default: begin
               idle_pct = 9;
               stall_pct = 9;
            end
         endcase

         r = $urandom_range(99);
         if (r < 10) v = {4'h4, 4'($urandom_range(4))};
         else if (r < 70) v = 8'h45;
         else v = {4'h4, 4'($urandom_range(15, 6))};
         if ($urandom_range(9) == 0) v[7:4] = 4'($urandom);
         hl = (v[3:0] < 4'd5) ? 20 : int'(v[3:0]) * 4;

         if ($urandom_range(1) == 0) tlen = 16'(hl + int'($urandom_range(40)));
         else tlen = 16'($urandom);
         r = $urandom_range(99);
         if (r < 30) fsz = 16'($urandom);
         else if (r < 70) fsz = 16'(tlen + 16'($urandom_range(64)));
         else fsz = 16'(tlen - 16'($urandom_range(64, 1)));

         room = hl - 20;
         opts = {};
         while (opts.size() < room) begin
            r = $urandom_range(99);
            if (r < 25) begin
               opts = {opts, ihp_pkg::KIND_NOP};
            end else if (r < 33) begin
               opts = {opts, ihp_pkg::KIND_END};
            end else if (r < 48) begin
               opts = {opts, ihp_pkg::KIND_ROUTER_ALERT};
               opts = {opts, 8'd4};
               opts = {opts, 8'($urandom)};
               opts = {opts, 8'($urandom)};
            end else if (r < 75) begin
               len = $urandom_range((room - opts.size() > 2) ? room - opts.size() : 2, 2);
               opts = {opts, 8'($urandom_range(255, 2))};
               opts = {opts, 8'(len)};
               repeat (len - 2) opts = {opts, 8'($urandom)};
            end else if (r < 85) begin
               opts = {opts, 8'($urandom_range(255, 2))};
               case ($urandom_range(3))
                  0: opts = {opts, 8'd0};
                  1: opts = {opts, 8'd1};
                  2: opts = {opts, 8'd255};
                  default: opts = {opts, 8'($urandom)};
               endcase
            end else begin
               opts = {opts, 8'($urandom)};
            end
         end

         pkt = make_header(v, 8'($urandom), tlen, fsz, 16'($urandom), 16'($urandom),
                           8'($urandom), 8'($urandom), {$urandom, $urandom}, opts,
                           ($urandom_range(99) < 85));
         r = $urandom_range(99);
         if (r < 5) begin
            foreach (pkt[i]) pkt[i] = 8'($urandom);
            send_packet(pkt, fsz, $urandom_range(3));
         end else if (r < 13) begin
            n = $urandom_range(hl - 1, 1);
            pkt = pkt[0:n-1];
            send_packet(pkt, fsz, 0);
         end else begin
            send_packet(pkt, fsz, ($urandom_range(1) == 0) ? 0 : $urandom_range(6));
         end
      end

      req_if.valid <= 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      @(posedge clock);
      while (sb.expected_hdrs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_hdrs.size() != 0) begin
         sb.errors += sb.expected_hdrs.size();
         $display("ERROR: %0d expected headers never arrived", sb.expected_hdrs.size());
      end

      $display("Parsed %0d headers from %0d input words: %0d clamped, %0d bad checksum,",
               sb.checked, words_sent, sb.n_clamped, sb.n_bad_sum);
      $display("  %0d with router alert, %0d with unknown or malformed options, %0d errors.",
               sb.n_alert, sb.n_unknown, sb.errors);
      if (sb.errors == 0) begin
         $display("** ipv4_header_parser_core: PASSED **");
      end else begin
         $display("** ipv4_header_parser_core: FAILED **");
      end
      $finish;
   end

endmodule
